FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the list core; compiled out under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge of clk outside reset
`define PAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never hold on a rising edge of clk outside reset
`define PAL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define PAL_ASSERT(lbl, prop, msg)
`define PAL_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: design/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Types, codes and elaboration helpers for the positional array list core.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int TREE_FANIN   = 8;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // control broadcast to every cell of the list
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } pal_ctl_t;

  // number of nodes on level k of the read tree (level 0 = leaves)
  function automatic int tree_width(input int n, input int k);
    int m;
    m = n;
    for (int j = 0; j < k; j++) begin
      m = (m + TREE_FANIN - 1) / TREE_FANIN;
    end
    return m;
  endfunction

  // number of registered levels above the leaves
  function automatic int tree_levels(input int n);
    int m;
    int l;
    m = n;
    l = 0;
    while (m > 1) begin
      m = (m + TREE_FANIN - 1) / TREE_FANIN;
      l++;
    end
    return l;
  endfunction

  // flat offset of registered level k (k >= 1) in the node array
  function automatic int tree_offset(input int n, input int k);
    int s;
    s = 0;
    for (int j = 1; j < k; j++) begin
      s = s + tree_width(n, j);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry, shifts up or down with its neighbors and
// offers its entry to the read tree when its index is selected.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell #(
  parameter int IDX = 0
) (
  input  wire                          clk,
  input  wire  pal_pkg::pal_ctl_t      ctl,
  input  wire  [pal_pkg::DATA_W-1:0]   left_i,
  input  wire  [pal_pkg::DATA_W-1:0]   right_i,
  output logic [pal_pkg::DATA_W-1:0]   entry_o,
  output logic [pal_pkg::DATA_W-1:0]   leaf_o
);

  import pal_pkg::*;

  localparam logic [15:0] IdxC = 16'(IDX);

  logic [DATA_W-1:0] entry_r;
  logic [DATA_W-1:0] entry_nxt;
  logic [15:0]       pos_ext;
  logic              above;
  logic              here;

  assign pos_ext = 16'(ctl.pos);
  assign above   = (IdxC > pos_ext);
  assign here    = (IdxC == pos_ext);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && above) begin
      entry_nxt = left_i;
    end else if (ctl.ins_en && here) begin
      entry_nxt = ctl.value;
    end else if (ctl.del_en && (above || here)) begin
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign leaf_o  = here ? entry_r : '0;

endmodule

`default_nettype wire

FILE: design/pal_or_tree.sv
// ----------------------------------------------------------------------------
// pal_or_tree
// Registered OR tree that gathers the one selected cell entry; one level of
// eight-input ORs per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_or_tree #(
  parameter int N = pal_pkg::CAPACITY_DEF
) (
  input  wire                         clk,
  input  wire  [pal_pkg::DATA_W-1:0]  leaf [N],
  output logic [pal_pkg::DATA_W-1:0]  top_o
);

  import pal_pkg::*;

  localparam int Lvls  = tree_levels(N);
  localparam int Nodes = tree_offset(N, Lvls + 1);

  logic [DATA_W-1:0] node_r [Nodes];

  for (genvar k = 1; k <= Lvls; k++) begin : g_lvl
    localparam int Nw   = tree_width(N, k);
    localparam int Pw   = tree_width(N, k - 1);
    localparam int Off  = tree_offset(N, k);
    localparam int Poff = tree_offset(N, k - 1);
    for (genvar j = 0; j < Nw; j++) begin : g_node
      logic [DATA_W-1:0] kid [TREE_FANIN];
      logic [DATA_W-1:0] acc;
      for (genvar c = 0; c < TREE_FANIN; c++) begin : g_kid
        if (j * TREE_FANIN + c < Pw) begin : g_used
          if (k == 1) begin : g_leaf
            assign kid[c] = leaf[j * TREE_FANIN + c];
          end else begin : g_inner
            assign kid[c] = node_r[Poff + j * TREE_FANIN + c];
          end
        end else begin : g_pad
          assign kid[c] = '0;
        end
      end
      always_comb begin
        acc = '0;
        for (int c = 0; c < TREE_FANIN; c++) begin
          acc = acc | kid[c];
        end
      end
      always_ff @(posedge clk) begin
        node_r[Off + j] <= acc;
      end
    end
  end

  assign top_o = node_r[Nodes - 1];

endmodule

`default_nettype wire

FILE: design/positional_array_list_core.sv
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of signed 32-bit entries with insert, delete, read and clear
// at a position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command word per handshake: action, position and value.
//   out_* : one result word per command: status, data read or deleted, new
//           length, empty and full flags.
//   A command is taken while the core is idle. The selected entry is gathered
//   by a registered OR tree of L = ceil(log8(CAPACITY)) levels (3 for 128);
//   the result is registered once the wait for the tree ends, and the next
//   command is taken only after that, so a new command is not accepted
//   while the last one is still in flight. The tree depth sets the wait.
//   Insert and delete shift every later cell by one place, all at once.
//   If the receiver stalls, the result waits in the output register; the core
//   takes one more command and holds its result back until the register frees.
//   Reset empties the list (length zero); entry contents are not cleared and
//   are only read after they have been written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module positional_array_list_core #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // action[1:0], position[9:2], value[41:10]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata   // status[1:0], data_out[33:2], length[41:34],
                                  // empty_flag[42], full_flag[43]
);

  import pal_pkg::*;

  localparam int TreeL = tree_levels(CAPACITY);
  localparam int CntW  = $clog2(TreeL + 1);
  localparam int LenW  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic [LenW-1:0]    count_r, count_nxt;
  logic [1:0]         act_r;
  logic [POS_W-1:0]   pos_r;
  logic [DATA_W-1:0]  val_r;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [7:0]         out_len_r;
  logic               out_empty_r;
  logic               out_full_r;

  logic               in_acc;
  logic               commit;
  logic [1:0]         status;
  logic               ok;
  logic [15:0]        pos16;
  logic [15:0]        cnt16;
  logic [15:0]        len16;
  logic [DATA_W-1:0]  tree_top;
  logic [DATA_W-1:0]  data_res;
  pal_ctl_t           ctl;

  logic [DATA_W-1:0]  ent  [CAPACITY];
  logic [DATA_W-1:0]  leaf [CAPACITY];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign commit    = (state_r == S_WAIT) && (cnt_r == CntW'(TreeL)) &&
                     (!out_valid_r || out_tready);

  // status of the latched command against the current length
  assign pos16 = 16'(pos_r);
  assign cnt16 = 16'(count_r);
  always_comb begin
    status = ST_DONE;
    case (act_r)
      ACT_INSERT: begin
        if (count_r == LenW'(CAPACITY)) begin
          status = ST_FULL;
        end else if (pos16 > cnt16) begin
          status = ST_RANGE;
        end
      end
      ACT_DELETE, ACT_READ: begin
        if (pos16 >= cnt16) begin
          status = ST_RANGE;
        end
      end
      default: status = ST_DONE;
    endcase
  end
  assign ok = (status == ST_DONE);

  assign ctl.ins_en = commit && ok && (act_r == ACT_INSERT);
  assign ctl.del_en = commit && ok && (act_r == ACT_DELETE);
  assign ctl.pos    = pos_r;
  assign ctl.value  = val_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = ent[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = ent[i + 1];
    end
    pal_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (ent[i]),
      .leaf_o  (leaf[i])
    );
  end

  pal_or_tree #(.N(CAPACITY)) u_tree (
    .clk   (clk),
    .leaf  (leaf),
    .top_o (tree_top)
  );

  always_comb begin
    count_nxt = count_r;
    if (commit) begin
      if (act_r == ACT_CLEAR) begin
        count_nxt = '0;
      end else if (ctl.ins_en) begin
        count_nxt = count_r + 1'b1;
      end else if (ctl.del_en) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  assign data_res = (ok && (act_r == ACT_DELETE || act_r == ACT_READ)) ? tree_top : '0;
  assign len16    = 16'(count_nxt);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_WAIT;
          cnt_nxt   = '0;
        end
      end
      S_WAIT: begin
        if (cnt_r != CntW'(TreeL)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tdata[1:0];
      pos_r <= in_tdata[9:2];
      val_r <= in_tdata[41:10];
    end
    if (commit) begin
      out_status_r <= status;
      out_data_r   <= data_res;
      out_len_r    <= len16[7:0];
      out_empty_r  <= (count_nxt == '0);
      out_full_r   <= (count_nxt == LenW'(CAPACITY));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_full_r, out_empty_r, out_len_r, out_data_r, out_status_r};

  `PAL_ASSERT_NEVER(a_count_cap, count_r > LenW'(CAPACITY), "length above capacity")
  `PAL_ASSERT(a_accept_wait, in_acc |=> (state_r == S_WAIT && cnt_r == '0), "accept did not start wait")
  `PAL_ASSERT(a_ins_count, ctl.ins_en |=> (count_r == $past(count_r) + 1'b1), "insert did not grow list")
  `PAL_ASSERT(a_commit_out, commit |=> (out_valid_r && state_r == S_IDLE), "result not registered")

endmodule

`default_nettype wire
